@@ rtl/core/uvsg_pkg.sv @@
// shared constants, types and sine coefficients for the uv sphere vertex generator
package uvsg_pkg;

  localparam int unsigned ANG_W       = 16;
  localparam int unsigned QTR_W       = ANG_W - 2;
  localparam int unsigned IDX_W       = 8;
  localparam int unsigned CNT_W       = 9;
  localparam int unsigned RAD_W       = 16;
  localparam int unsigned COORD_W     = 17;
  localparam int unsigned MAG_W       = 16;
  localparam int unsigned MAG_FRAC    = 15;
  localparam int unsigned MAX_SECTORS = 256;
  localparam int unsigned MAX_RINGS   = 256;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 16;

  localparam int unsigned DIV_NW      = ANG_W + IDX_W + 1;
  localparam int unsigned DIV_DW      = CNT_W + 1;

  localparam int unsigned COEF_W      = 31;
  localparam int unsigned U_W         = 31;
  localparam int unsigned POLY_FRAC   = 30;
  localparam int unsigned U_SHIFT     = POLY_FRAC - QTR_W;
  localparam int unsigned HORNER      = 5;
  localparam int unsigned QS_LAT      = HORNER + 3;

  typedef enum logic [1:0] {
    FN_TOP    = 2'd0,
    FN_RING   = 2'd1,
    FN_BOTTOM = 2'd2,
    FN_ERROR  = 2'd3
  } func_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RADIUS  = 2'd0,
    CFG_SECTORS = 2'd1,
    CFG_STACKS  = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic  valid;
    func_e kind;
  } tag_t;

  typedef struct packed {
    logic [MAG_W-1:0] se_mag;
    logic             se_neg;
    logic [MAG_W-1:0] ce_mag;
    logic             ce_neg;
    logic [MAG_W-1:0] sa_mag;
    logic             sa_neg;
    logic [MAG_W-1:0] ca_mag;
    logic             ca_neg;
  } trig_t;

  // odd polynomial for sin(pi/2 * u), q30 magnitudes, signs alternate
  function automatic logic [COEF_W-1:0] sin_coef(input int unsigned k);
    logic [COEF_W-1:0] c;
    case (k)
      0: c = 31'd1686629713;
      1: c = 31'd693598668;
      2: c = 31'd85569306;
      3: c = 31'd5026995;
      4: c = 31'd172272;
      5: c = 31'd3864;
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

@@ rtl/core/uv_sphere_vertex_generator_top.sv @@
// top level of the uv sphere vertex generator
// One vertex per start beat, one beat per clock with no gaps: busy never rises. Each
// result appears on the coord ports with done_o high for a single cycle, in start
// order, and cannot be held off by the receiver. The pipeline runs through the
// 16-stage angle divider (one quotient bit per stage), the 8-stage sine polynomial
// and three radius scaling stages. Configuration writes are always ready
// and take effect at once; write them only while no vertex is in flight.
module uv_sphere_vertex_generator_top (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   start,
  output logic                                   busy,
  input  logic [1:0]                             func_i,
  input  logic [uvsg_pkg::IDX_W-1:0]             ring_index_i,
  input  logic [uvsg_pkg::IDX_W-1:0]             sector_index_i,
  output logic                                   done_o,
  output logic signed [uvsg_pkg::COORD_W-1:0]    coord_x_o,
  output logic signed [uvsg_pkg::COORD_W-1:0]    coord_y_o,
  output logic signed [uvsg_pkg::COORD_W-1:0]    coord_z_o,
  output logic                                   index_error_o,
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [uvsg_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [uvsg_pkg::CFG_DATA_W-1:0]        cfg_data_i
);

  localparam int unsigned CNT_W = uvsg_pkg::CNT_W;
  localparam int unsigned ANG_W = uvsg_pkg::ANG_W;
  localparam int unsigned NW    = uvsg_pkg::DIV_NW;
  localparam int unsigned DW    = uvsg_pkg::DIV_DW;
  localparam int unsigned RAD_W = uvsg_pkg::RAD_W;
  localparam int unsigned CW    = uvsg_pkg::COORD_W;

  logic [RAD_W-1:0] radius_q;
  logic [CNT_W-1:0] sectors_q;
  logic [CNT_W-1:0] stacks_q;

  logic [CNT_W-1:0] ns;
  logic [CNT_W-1:0] nr;
  logic [CNT_W-1:0] ring_p1;
  logic [CNT_W:0]   nr_p1;
  uvsg_pkg::tag_t   tag_d;
  logic [NW-1:0]    num_a_d;
  logic [DW-1:0]    den_a_d;
  logic [NW-1:0]    num_b_d;
  logic [DW-1:0]    den_b_d;

  uvsg_pkg::tag_t   tag0_q;
  logic [NW-1:0]    num_a_q;
  logic [DW-1:0]    den_a_q;
  logic [NW-1:0]    num_b_q;
  logic [DW-1:0]    den_b_q;

  uvsg_pkg::tag_t   div_tag;
  logic [ANG_W-1:0] phase;
  logic [ANG_W-1:0] az;
  uvsg_pkg::tag_t   sc_tag;
  uvsg_pkg::trig_t  trig;

  logic [CW-1:0]    x;
  logic [CW-1:0]    y;
  logic [CW-1:0]    z;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q  <= RAD_W'(256);
      sectors_q <= CNT_W'(16);
      stacks_q  <= CNT_W'(8);
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (uvsg_pkg::cfg_reg_e'(cfg_index_i))
        uvsg_pkg::CFG_RADIUS:  radius_q  <= cfg_data_i[RAD_W-1:0];
        uvsg_pkg::CFG_SECTORS: sectors_q <= cfg_data_i[CNT_W-1:0];
        uvsg_pkg::CFG_STACKS:  stacks_q  <= cfg_data_i[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign ns = (sectors_q > CNT_W'(uvsg_pkg::MAX_SECTORS)) ?
              CNT_W'(uvsg_pkg::MAX_SECTORS) : sectors_q;
  assign nr = (stacks_q > CNT_W'(uvsg_pkg::MAX_RINGS)) ?
              CNT_W'(uvsg_pkg::MAX_RINGS) : stacks_q;

  always_comb begin
    tag_d.valid = start && !busy;
    case (uvsg_pkg::func_e'(func_i))
      uvsg_pkg::FN_TOP:    tag_d.kind = uvsg_pkg::FN_TOP;
      uvsg_pkg::FN_BOTTOM: tag_d.kind = uvsg_pkg::FN_BOTTOM;
      uvsg_pkg::FN_RING: begin
        if ((CNT_W'(ring_index_i) >= nr) || (CNT_W'(sector_index_i) >= ns)) begin
          tag_d.kind = uvsg_pkg::FN_ERROR;
        end else begin
          tag_d.kind = uvsg_pkg::FN_RING;
        end
      end
      default: tag_d.kind = uvsg_pkg::FN_ERROR;
    endcase
  end

  // ring phase = ((ring+1)*turn + (nr+1)) / (2*(nr+1))
  // azimuth    = (sector*turn + ns/2) / ns
  assign ring_p1 = CNT_W'(ring_index_i) + CNT_W'(1);
  assign nr_p1   = (CNT_W+1)'(nr) + (CNT_W+1)'(1);
  assign num_a_d = NW'({ring_p1, ANG_W'(0)}) + NW'(nr_p1);
  assign den_a_d = DW'({nr_p1, 1'b0});
  assign num_b_d = NW'({sector_index_i, ANG_W'(0)}) + NW'(ns >> 1);
  assign den_b_d = DW'(ns);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag0_q <= '0;
    end else begin
      tag0_q <= tag_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_a_q <= num_a_d;
    den_a_q <= den_a_d;
    num_b_q <= num_b_d;
    den_b_q <= den_b_d;
  end

  uvsg_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .tag_i   (tag0_q),
    .num_a_i (num_a_q),
    .den_a_i (den_a_q),
    .num_b_i (num_b_q),
    .den_b_i (den_b_q),
    .tag_o   (div_tag),
    .quo_a_o (phase),
    .quo_b_o (az)
  );

  uvsg_sincos u_sincos (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .tag_i   (div_tag),
    .phase_i (phase),
    .az_i    (az),
    .tag_o   (sc_tag),
    .trig_o  (trig)
  );

  uvsg_scale u_scale (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .tag_i    (sc_tag),
    .trig_i   (trig),
    .radius_i (radius_q),
    .valid_o  (done_o),
    .x_o      (x),
    .y_o      (y),
    .z_o      (z),
    .err_o    (index_error_o)
  );

  assign coord_x_o = $signed(x);
  assign coord_y_o = $signed(y);
  assign coord_z_o = $signed(z);

endmodule

@@ rtl/core/uvsg_div.sv @@
// pipelined restoring divider, two lanes, one quotient bit per stage
module uvsg_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  uvsg_pkg::tag_t                 tag_i,
  input  logic [uvsg_pkg::DIV_NW-1:0]    num_a_i,
  input  logic [uvsg_pkg::DIV_DW-1:0]    den_a_i,
  input  logic [uvsg_pkg::DIV_NW-1:0]    num_b_i,
  input  logic [uvsg_pkg::DIV_DW-1:0]    den_b_i,
  output uvsg_pkg::tag_t                 tag_o,
  output logic [uvsg_pkg::ANG_W-1:0]     quo_a_o,
  output logic [uvsg_pkg::ANG_W-1:0]     quo_b_o
);

  localparam int unsigned STAGES = uvsg_pkg::ANG_W;
  localparam int unsigned NW     = uvsg_pkg::DIV_NW;
  localparam int unsigned DW     = uvsg_pkg::DIV_DW;
  localparam int unsigned SH_W   = DW + STAGES;

  uvsg_pkg::tag_t          tag_in   [STAGES];
  uvsg_pkg::tag_t          tag_q    [STAGES];
  logic [NW-1:0]           rem_a_in [STAGES];
  logic [NW-1:0]           rem_a_q  [STAGES];
  logic [NW-1:0]           rem_b_in [STAGES];
  logic [NW-1:0]           rem_b_q  [STAGES];
  logic [DW-1:0]           den_a_in [STAGES];
  logic [DW-1:0]           den_a_q  [STAGES];
  logic [DW-1:0]           den_b_in [STAGES];
  logic [DW-1:0]           den_b_q  [STAGES];
  logic [STAGES-1:0]       quo_a_in [STAGES];
  logic [STAGES-1:0]       quo_a_q  [STAGES];
  logic [STAGES-1:0]       quo_b_in [STAGES];
  logic [STAGES-1:0]       quo_b_q  [STAGES];

  for (genvar s = 0; s < STAGES; s++) begin : g_stage
    logic [SH_W-1:0] dsh_a;
    logic [SH_W-1:0] dsh_b;
    logic            ge_a;
    logic            ge_b;

    if (s == 0) begin : g_first
      assign tag_in[s]   = tag_i;
      assign rem_a_in[s] = num_a_i;
      assign rem_b_in[s] = num_b_i;
      assign den_a_in[s] = den_a_i;
      assign den_b_in[s] = den_b_i;
      assign quo_a_in[s] = '0;
      assign quo_b_in[s] = '0;
    end else begin : g_next
      assign tag_in[s]   = tag_q[s-1];
      assign rem_a_in[s] = rem_a_q[s-1];
      assign rem_b_in[s] = rem_b_q[s-1];
      assign den_a_in[s] = den_a_q[s-1];
      assign den_b_in[s] = den_b_q[s-1];
      assign quo_a_in[s] = quo_a_q[s-1];
      assign quo_b_in[s] = quo_b_q[s-1];
    end

    assign dsh_a = SH_W'(den_a_in[s]) << (STAGES - 1 - s);
    assign dsh_b = SH_W'(den_b_in[s]) << (STAGES - 1 - s);
    assign ge_a  = SH_W'(rem_a_in[s]) >= dsh_a;
    assign ge_b  = SH_W'(rem_b_in[s]) >= dsh_b;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        tag_q[s] <= '0;
      end else begin
        tag_q[s] <= tag_in[s];
      end
    end

    always_ff @(posedge clk_i) begin
      rem_a_q[s] <= ge_a ? (rem_a_in[s] - dsh_a[NW-1:0]) : rem_a_in[s];
      rem_b_q[s] <= ge_b ? (rem_b_in[s] - dsh_b[NW-1:0]) : rem_b_in[s];
      den_a_q[s] <= den_a_in[s];
      den_b_q[s] <= den_b_in[s];
      quo_a_q[s] <= {quo_a_in[s][STAGES-2:0], ge_a};
      quo_b_q[s] <= {quo_b_in[s][STAGES-2:0], ge_b};
    end
  end

  assign tag_o   = tag_q[STAGES-1];
  assign quo_a_o = quo_a_q[STAGES-1];
  assign quo_b_o = quo_b_q[STAGES-1];

endmodule

@@ rtl/core/uvsg_qsine.sv @@
// pipelined quarter-wave sine, horner polynomial, one multiply per stage
module uvsg_qsine (
  input  logic                           clk_i,
  input  logic [uvsg_pkg::QTR_W:0]       r_i,
  output logic [uvsg_pkg::MAG_W-1:0]     mag_o
);

  localparam int unsigned U_W    = uvsg_pkg::U_W;
  localparam int unsigned P_W    = 2 * U_W;
  localparam int unsigned FR     = uvsg_pkg::POLY_FRAC;
  localparam int unsigned HORNER = uvsg_pkg::HORNER;
  localparam int unsigned MF     = uvsg_pkg::MAG_FRAC;
  localparam int unsigned MAG_W  = uvsg_pkg::MAG_W;

  logic [U_W-1:0] u;
  logic [P_W-1:0] sq;
  logic [P_W-1:0] fin;
  logic [U_W:0]   rnd;
  logic [U_W-MF:0] shr;

  logic [U_W-1:0] u_q  [HORNER+1];
  logic [U_W-1:0] u2_q [HORNER];
  logic [uvsg_pkg::COEF_W-1:0] p_q [HORNER+1];
  logic [U_W-1:0] pu_q;
  logic [MAG_W-1:0] mag_q;

  assign u  = U_W'(r_i) << uvsg_pkg::U_SHIFT;
  assign sq = P_W'(u) * P_W'(u);

  always_ff @(posedge clk_i) begin
    u_q[0]  <= u;
    u2_q[0] <= sq[U_W+FR-1:FR];
    p_q[0]  <= uvsg_pkg::sin_coef(HORNER);
  end

  for (genvar j = 1; j <= HORNER; j++) begin : g_horner
    logic [P_W-1:0] prod;
    assign prod = P_W'(p_q[j-1]) * P_W'(u2_q[j-1]);

    always_ff @(posedge clk_i) begin
      p_q[j] <= uvsg_pkg::sin_coef(HORNER - j) - prod[U_W+FR-1:FR];
      u_q[j] <= u_q[j-1];
    end

    if (j < HORNER) begin : g_u2
      always_ff @(posedge clk_i) begin
        u2_q[j] <= u2_q[j-1];
      end
    end
  end

  assign fin = P_W'(p_q[HORNER]) * P_W'(u_q[HORNER]);
  assign rnd = (U_W+1)'(pu_q) + (U_W+1)'(1 << (MF - 1));
  assign shr = rnd[U_W:MF];

  always_ff @(posedge clk_i) begin
    pu_q  <= fin[U_W+FR-1:FR];
    mag_q <= (shr > (U_W-MF+1)'(1 << MF)) ? MAG_W'(1 << MF) : shr[MAG_W-1:0];
  end

  assign mag_o = mag_q;

endmodule

@@ rtl/core/uvsg_sincos.sv @@
// elevation and azimuth to sine and cosine magnitudes with signs
module uvsg_sincos (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  uvsg_pkg::tag_t                tag_i,
  input  logic [uvsg_pkg::ANG_W-1:0]    phase_i,
  input  logic [uvsg_pkg::ANG_W-1:0]    az_i,
  output uvsg_pkg::tag_t                tag_o,
  output uvsg_pkg::trig_t               trig_o
);

  localparam int unsigned ANG_W = uvsg_pkg::ANG_W;
  localparam int unsigned QTR_W = uvsg_pkg::QTR_W;
  localparam int unsigned LAT   = uvsg_pkg::QS_LAT;
  localparam int unsigned MAG_W = uvsg_pkg::MAG_W;

  typedef struct packed {
    uvsg_pkg::tag_t tag;
    logic [1:0]     qel;
    logic [1:0]     qaz;
  } sc_tag_t;

  logic [ANG_W-1:0] el;
  logic [QTR_W:0]   r_el;
  logic [QTR_W:0]   r_az;
  sc_tag_t          in_tag;
  sc_tag_t          dly_q [LAT+1];

  logic [QTR_W:0]   r_el_q;
  logic [QTR_W:0]   c_el_q;
  logic [QTR_W:0]   r_az_q;
  logic [QTR_W:0]   c_az_q;

  logic [MAG_W-1:0] m_r_el;
  logic [MAG_W-1:0] m_c_el;
  logic [MAG_W-1:0] m_r_az;
  logic [MAG_W-1:0] m_c_az;

  uvsg_pkg::trig_t  trig_d;
  uvsg_pkg::trig_t  trig_q;
  uvsg_pkg::tag_t   tag_q;

  // elevation is a quarter turn minus the ring phase
  assign el   = (ANG_W'(1) << QTR_W) - phase_i;
  assign r_el = {1'b0, el[QTR_W-1:0]};
  assign r_az = {1'b0, az_i[QTR_W-1:0]};

  assign in_tag.tag = tag_i;
  assign in_tag.qel = el[ANG_W-1:QTR_W];
  assign in_tag.qaz = az_i[ANG_W-1:QTR_W];

  always_ff @(posedge clk_i) begin
    r_el_q <= r_el;
    c_el_q <= ((QTR_W+1)'(1) << QTR_W) - r_el;
    r_az_q <= r_az;
    c_az_q <= ((QTR_W+1)'(1) << QTR_W) - r_az;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i <= LAT; i++) begin
        dly_q[i] <= '0;
      end
    end else begin
      dly_q[0] <= in_tag;
      for (int i = 1; i <= LAT; i++) begin
        dly_q[i] <= dly_q[i-1];
      end
    end
  end

  uvsg_qsine u_qs_r_el (.clk_i(clk_i), .r_i(r_el_q), .mag_o(m_r_el));
  uvsg_qsine u_qs_c_el (.clk_i(clk_i), .r_i(c_el_q), .mag_o(m_c_el));
  uvsg_qsine u_qs_r_az (.clk_i(clk_i), .r_i(r_az_q), .mag_o(m_r_az));
  uvsg_qsine u_qs_c_az (.clk_i(clk_i), .r_i(c_az_q), .mag_o(m_c_az));

  // odd quadrants read the mirrored quarter wave
  always_comb begin
    trig_d.se_mag = dly_q[LAT].qel[0] ? m_c_el : m_r_el;
    trig_d.se_neg = dly_q[LAT].qel[1];
    trig_d.ce_mag = dly_q[LAT].qel[0] ? m_r_el : m_c_el;
    trig_d.ce_neg = dly_q[LAT].qel[1] ^ dly_q[LAT].qel[0];
    trig_d.sa_mag = dly_q[LAT].qaz[0] ? m_c_az : m_r_az;
    trig_d.sa_neg = dly_q[LAT].qaz[1];
    trig_d.ca_mag = dly_q[LAT].qaz[0] ? m_r_az : m_c_az;
    trig_d.ca_neg = dly_q[LAT].qaz[1] ^ dly_q[LAT].qaz[0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q <= '0;
    end else begin
      tag_q <= dly_q[LAT].tag;
    end
  end

  always_ff @(posedge clk_i) begin
    trig_q <= trig_d;
  end

  assign tag_o  = tag_q;
  assign trig_o = trig_q;

endmodule

@@ rtl/core/uvsg_scale.sv @@
// radius scaling, rounding and result selection
module uvsg_scale (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  uvsg_pkg::tag_t                 tag_i,
  input  uvsg_pkg::trig_t                trig_i,
  input  logic [uvsg_pkg::RAD_W-1:0]     radius_i,
  output logic                           valid_o,
  output logic [uvsg_pkg::COORD_W-1:0]   x_o,
  output logic [uvsg_pkg::COORD_W-1:0]   y_o,
  output logic [uvsg_pkg::COORD_W-1:0]   z_o,
  output logic                           err_o
);

  localparam int unsigned RAD_W = uvsg_pkg::RAD_W;
  localparam int unsigned MAG_W = uvsg_pkg::MAG_W;
  localparam int unsigned MF    = uvsg_pkg::MAG_FRAC;
  localparam int unsigned CW    = uvsg_pkg::COORD_W;
  localparam int unsigned P1_W  = RAD_W + MAG_W;
  localparam int unsigned P2_W  = P1_W + MAG_W;

  uvsg_pkg::tag_t   tag1_q;
  logic [P1_W-1:0]  yp1_q;
  logic [P1_W-1:0]  cx1_q;
  logic [MAG_W-1:0] sa1_q;
  logic [MAG_W-1:0] ca1_q;
  logic             yneg1_q;
  logic             xneg1_q;
  logic             zneg1_q;

  uvsg_pkg::tag_t   tag2_q;
  logic [P2_W-1:0]  xp2_q;
  logic [P2_W-1:0]  zp2_q;
  logic [CW-1:0]    y2_q;
  logic             xneg2_q;
  logic             zneg2_q;

  logic [P1_W:0]    ysum;
  logic [CW-1:0]    ypos;
  logic [P2_W-1:0]  xsum;
  logic [P2_W-1:0]  zsum;
  logic [CW-1:0]    xpos;
  logic [CW-1:0]    zpos;
  logic [CW-1:0]    rpos;

  logic             valid_q;
  logic [CW-1:0]    x_d;
  logic [CW-1:0]    y_d;
  logic [CW-1:0]    z_d;
  logic             err_d;
  logic [CW-1:0]    x_q;
  logic [CW-1:0]    y_q;
  logic [CW-1:0]    z_q;
  logic             err_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag1_q  <= '0;
      tag2_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      tag1_q  <= tag_i;
      tag2_q  <= tag1_q;
      valid_q <= tag2_q.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    yp1_q   <= P1_W'(radius_i) * P1_W'(trig_i.se_mag);
    cx1_q   <= P1_W'(radius_i) * P1_W'(trig_i.ce_mag);
    sa1_q   <= trig_i.sa_mag;
    ca1_q   <= trig_i.ca_mag;
    yneg1_q <= trig_i.se_neg;
    xneg1_q <= trig_i.ce_neg ^ trig_i.sa_neg;
    zneg1_q <= trig_i.ce_neg ^ trig_i.ca_neg;
  end

  // round half away from zero on the magnitude, then apply the sign
  assign ysum = (P1_W+1)'(yp1_q) + (P1_W+1)'(1 << (MF - 1));
  assign ypos = CW'(ysum[P1_W:MF]);

  always_ff @(posedge clk_i) begin
    xp2_q   <= P2_W'(cx1_q) * P2_W'(sa1_q);
    zp2_q   <= P2_W'(cx1_q) * P2_W'(ca1_q);
    y2_q    <= yneg1_q ? (CW'(0) - ypos) : ypos;
    xneg2_q <= xneg1_q;
    zneg2_q <= zneg1_q;
  end

  assign xsum = xp2_q + P2_W'(1 << (2 * MF - 1));
  assign zsum = zp2_q + P2_W'(1 << (2 * MF - 1));
  assign xpos = CW'(xsum[P2_W-1:2*MF]);
  assign zpos = CW'(zsum[P2_W-1:2*MF]);
  assign rpos = CW'(radius_i);

  always_comb begin
    x_d   = '0;
    y_d   = '0;
    z_d   = '0;
    err_d = 1'b0;
    case (tag2_q.kind)
      uvsg_pkg::FN_TOP: begin
        y_d = rpos;
      end
      uvsg_pkg::FN_BOTTOM: begin
        y_d = CW'(0) - rpos;
      end
      uvsg_pkg::FN_RING: begin
        x_d = xneg2_q ? (CW'(0) - xpos) : xpos;
        y_d = y2_q;
        z_d = zneg2_q ? (CW'(0) - zpos) : zpos;
      end
      default: begin
        err_d = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    x_q   <= x_d;
    y_q   <= y_d;
    z_q   <= z_d;
    err_q <= err_d;
  end

  assign valid_o = valid_q;
  assign x_o     = x_q;
  assign y_o     = y_q;
  assign z_o     = z_q;
  assign err_o   = err_q;

endmodule

@@ dv/uv_sphere_vertex_generator_top_test.sv @@
// self-checking testbench for the uv sphere vertex generator top level
`timescale 1ns / 1ps

module uv_sphere_vertex_generator_top_test;

  localparam int unsigned ANG_W       = uvsg_pkg::ANG_W;
  localparam int unsigned QTR_W       = uvsg_pkg::QTR_W;
  localparam int unsigned IDX_W       = uvsg_pkg::IDX_W;
  localparam int unsigned CNT_W       = uvsg_pkg::CNT_W;
  localparam int unsigned RAD_W       = uvsg_pkg::RAD_W;
  localparam int unsigned COORD_W     = uvsg_pkg::COORD_W;
  localparam int unsigned CFG_IDX_W   = uvsg_pkg::CFG_IDX_W;
  localparam int unsigned CFG_DATA_W  = uvsg_pkg::CFG_DATA_W;
  localparam int unsigned POLY_FRAC   = uvsg_pkg::POLY_FRAC;
  localparam int unsigned MAX_SECTORS = uvsg_pkg::MAX_SECTORS;
  localparam int unsigned MAX_RINGS   = uvsg_pkg::MAX_RINGS;

  localparam longint unsigned TURN_UNITS    = 64'd1 << ANG_W;
  localparam longint unsigned QUARTER_UNITS = 64'd1 << QTR_W;
  localparam longint unsigned ANGLE_MASK    = TURN_UNITS - 1;
  localparam longint unsigned SIN_Q30 [0:5] = '{
    64'd1686629713, 64'd693598668, 64'd85569306, 64'd5026995, 64'd172272, 64'd3864
  };
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam int DRAIN_CYCLES = 40;

  typedef enum {JOB_VERTEX, JOB_CONFIG, JOB_SETTLE} job_kind_e;

  typedef struct {
    job_kind_e              kind;
    int                     gap;
    logic [1:0]             fn;
    logic [IDX_W-1:0]       ring;
    logic [IDX_W-1:0]       sector;
    logic [CFG_IDX_W-1:0]   cfg_idx;
    logic [CFG_DATA_W-1:0]  cfg_word;
  } job_t;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] z;
    logic               err;
  } vertex_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   start = 1'b0;
  logic                   busy;
  logic [1:0]             func_i = uvsg_pkg::FN_TOP;
  logic [IDX_W-1:0]       ring_index_i = '0;
  logic [IDX_W-1:0]       sector_index_i = '0;
  logic                   done_o;
  logic signed [COORD_W-1:0] coord_x_o;
  logic signed [COORD_W-1:0] coord_y_o;
  logic signed [COORD_W-1:0] coord_z_o;
  logic                   index_error_o;
  logic                   cfg_valid_i = 1'b0;
  logic                   cfg_ready_o;
  logic [CFG_IDX_W-1:0]   cfg_index_i = uvsg_pkg::CFG_RADIUS;
  logic [CFG_DATA_W-1:0]  cfg_data_i = '0;

  logic [RAD_W-1:0] radius_cfg = 16'd256;
  logic [CNT_W-1:0] sectors_cfg = 9'd16;
  logic [CNT_W-1:0] stacks_cfg = 9'd8;
  int plan_sectors = 16;
  int plan_stacks = 8;

  job_t    sphere_jobs[$];
  vertex_t vertex_due[$];
  int      mismatch_count = 0;

  uv_sphere_vertex_generator_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .func_i         (func_i),
    .ring_index_i   (ring_index_i),
    .sector_index_i (sector_index_i),
    .done_o         (done_o),
    .coord_x_o      (coord_x_o),
    .coord_y_o      (coord_y_o),
    .coord_z_o      (coord_z_o),
    .index_error_o  (index_error_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  function automatic longint unsigned quarter_wave(longint unsigned r);
    longint unsigned u, u2, p;
    int k;
    u = r << (POLY_FRAC - QTR_W);
    u2 = (u * u) >> 30;
    p = SIN_Q30[5];
    for (k = 4; k >= 0; k--) begin
      p = SIN_Q30[k] - ((p * u2) >> 30);
    end
    p = (p * u) >> 30;
    p = (p + (64'd1 << 14)) >> 15;
    return (p > 64'd32768) ? 64'd32768 : p;
  endfunction

  function automatic longint signed_sine(longint unsigned a);
    longint unsigned q, r, m;
    a = a & ANGLE_MASK;
    q = a >> QTR_W;
    r = a & (QUARTER_UNITS - 1);
    m = q[0] ? quarter_wave(QUARTER_UNITS - r) : quarter_wave(r);
    return q[1] ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint unsigned magnitude(longint v);
    return (v < 0) ? longint'(-v) : v;
  endfunction

  // round to nearest, ties away from zero
  function automatic longint round_scaled(longint unsigned mag, bit neg, int shift);
    longint unsigned v;
    v = (mag + (64'd1 << (shift - 1))) >> shift;
    return neg ? -longint'(v) : longint'(v);
  endfunction

  function automatic vertex_t sphere_vertex(logic [1:0] fn, logic [IDX_W-1:0] ring,
                                            logic [IDX_W-1:0] sector);
    vertex_t v;
    longint unsigned ns, nr, ri, si, den, phase, el, az, rad;
    longint se, ce, sa, ca, x, y, z;
    logic err;
    x = 0;
    y = 0;
    z = 0;
    err = 1'b0;
    rad = radius_cfg;
    ri = ring;
    si = sector;
    ns = sectors_cfg;
    nr = stacks_cfg;
    if (ns > MAX_SECTORS) ns = MAX_SECTORS;
    if (nr > MAX_RINGS) nr = MAX_RINGS;
    if (fn == uvsg_pkg::FN_TOP) begin
      y = rad;
    end else if (fn == uvsg_pkg::FN_BOTTOM) begin
      y = -longint'(rad);
    end else if (fn == uvsg_pkg::FN_ERROR || ri >= nr || si >= ns || ns == 0) begin
      err = 1'b1;
    end else begin
      den = 2 * (nr + 1);
      phase = ((ri + 1) * TURN_UNITS + (nr + 1)) / den;
      el = (QUARTER_UNITS + TURN_UNITS - (phase & ANGLE_MASK)) & ANGLE_MASK;
      az = ((si * TURN_UNITS + ns / 2) / ns) & ANGLE_MASK;
      se = signed_sine(el);
      ce = signed_sine(el + QUARTER_UNITS);
      sa = signed_sine(az);
      ca = signed_sine(az + QUARTER_UNITS);
      y = round_scaled(rad * magnitude(se), se < 0, 15);
      x = round_scaled(rad * magnitude(ce) * magnitude(sa), (ce < 0) != (sa < 0), 30);
      z = round_scaled(rad * magnitude(ce) * magnitude(ca), (ce < 0) != (ca < 0), 30);
    end
    v.x = x[COORD_W-1:0];
    v.y = y[COORD_W-1:0];
    v.z = z[COORD_W-1:0];
    v.err = err;
    return v;
  endfunction

  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic add_vertex(logic [1:0] fn, logic [IDX_W-1:0] ring,
                            logic [IDX_W-1:0] sector, int gap);
    job_t j;
    j = '{kind: JOB_VERTEX, gap: gap, fn: fn, ring: ring, sector: sector,
          cfg_idx: uvsg_pkg::CFG_RADIUS, cfg_word: '0};
    sphere_jobs.insert(sphere_jobs.size(), j);
  endtask

  task automatic add_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] word);
    job_t j;
    j = '{kind: JOB_CONFIG, gap: 0, fn: uvsg_pkg::FN_TOP, ring: '0, sector: '0,
          cfg_idx: idx, cfg_word: word};
    sphere_jobs.insert(sphere_jobs.size(), j);
    if (idx == uvsg_pkg::CFG_SECTORS) plan_sectors = int'(word[CNT_W-1:0]);
    if (idx == uvsg_pkg::CFG_STACKS) plan_stacks = int'(word[CNT_W-1:0]);
  endtask

  task automatic add_settle();
    job_t j;
    j = '{kind: JOB_SETTLE, gap: 0, fn: uvsg_pkg::FN_TOP, ring: '0, sector: '0,
          cfg_idx: uvsg_pkg::CFG_RADIUS, cfg_word: '0};
    sphere_jobs.insert(sphere_jobs.size(), j);
  endtask

  task automatic add_random_phase(int count, bit idle);
    int ns, nr, pick, i;
    logic [1:0] fn;
    logic [IDX_W-1:0] ring, sector;
    ns = (plan_sectors > MAX_SECTORS) ? MAX_SECTORS : plan_sectors;
    nr = (plan_stacks > MAX_RINGS) ? MAX_RINGS : plan_stacks;
    for (i = 0; i < count; i++) begin
      if (i == count / 2) add_settle();
      pick = $urandom_range(0, 99);
      fn = (pick < 10) ? uvsg_pkg::FN_TOP : (pick < 20) ? uvsg_pkg::FN_BOTTOM :
           (pick < 25) ? uvsg_pkg::FN_ERROR : uvsg_pkg::FN_RING;
      ring = IDX_W'($urandom);
      sector = IDX_W'($urandom);
      if (fn == uvsg_pkg::FN_RING && ns > 0 && nr > 0 && $urandom_range(0, 9) < 8) begin
        ring = IDX_W'($urandom_range(0, nr - 1));
        sector = IDX_W'($urandom_range(0, ns - 1));
      end
      add_vertex(fn, ring, sector, idle ? idle_gap() : 0);
    end
  endtask

  task automatic add_sphere(logic [CFG_DATA_W-1:0] rad, logic [CFG_DATA_W-1:0] sectors,
                            logic [CFG_DATA_W-1:0] stacks);
    add_config(uvsg_pkg::CFG_RADIUS, rad);
    add_config(uvsg_pkg::CFG_SECTORS, sectors);
    add_config(uvsg_pkg::CFG_STACKS, stacks);
  endtask

  task automatic flag_mismatch(string msg);
    $display("ERROR @%0t: %s", $time, msg);
    mismatch_count++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : drive_jobs
    logic start_d, cfg_valid_d, took;
    int   idle_left;
    job_t job;
    if (!rst_ni) begin
      start <= 1'b0;
      func_i <= uvsg_pkg::FN_TOP;
      ring_index_i <= '0;
      sector_index_i <= '0;
      cfg_valid_i <= 1'b0;
      cfg_index_i <= uvsg_pkg::CFG_RADIUS;
      cfg_data_i <= '0;
      idle_left = 0;
      radius_cfg = 16'd256;
      sectors_cfg = 9'd16;
      stacks_cfg = 9'd8;
    end else begin
      start_d = start;
      cfg_valid_d = cfg_valid_i;
      took = 1'b0;
      if (start && !busy) begin
        vertex_due.insert(vertex_due.size(),
                          sphere_vertex(func_i, ring_index_i, sector_index_i));
        start_d = 1'b0;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          uvsg_pkg::CFG_RADIUS:  radius_cfg = cfg_data_i;
          uvsg_pkg::CFG_SECTORS: sectors_cfg = cfg_data_i[CNT_W-1:0];
          uvsg_pkg::CFG_STACKS:  stacks_cfg = cfg_data_i[CNT_W-1:0];
          default: ;
        endcase
        cfg_valid_d = 1'b0;
      end
      if (!start_d && !cfg_valid_d && sphere_jobs.size() > 0) begin
        if (idle_left > 0) begin
          idle_left--;
        end else begin
          job = sphere_jobs[0];
          case (job.kind)
            JOB_VERTEX: begin
              func_i <= job.fn;
              ring_index_i <= job.ring;
              sector_index_i <= job.sector;
              start_d = 1'b1;
              took = 1'b1;
            end
            JOB_CONFIG: begin
              if (vertex_due.size() == 0) begin
                cfg_index_i <= job.cfg_idx;
                cfg_data_i <= job.cfg_word;
                cfg_valid_d = 1'b1;
                took = 1'b1;
              end
            end
            default: begin
              if (vertex_due.size() == 0) took = 1'b1;
            end
          endcase
          if (took) begin
            void'(sphere_jobs.pop_front());
            if (sphere_jobs.size() > 0) idle_left = sphere_jobs[0].gap;
          end
        end
      end
      start <= start_d;
      cfg_valid_i <= cfg_valid_d;
    end
  end

  always @(posedge clk_i) begin : check_vertices
    vertex_t want;
    if (rst_ni && done_o) begin
      if (vertex_due.size() == 0) begin
        flag_mismatch($sformatf("vertex beat with none pending: x=%0d y=%0d z=%0d err=%0b",
                                coord_x_o, coord_y_o, coord_z_o, index_error_o));
      end else begin
        want = vertex_due.pop_front();
        if (coord_x_o !== want.x)
          flag_mismatch($sformatf("coord_x %0d, want %0d", coord_x_o, $signed(want.x)));
        if (coord_y_o !== want.y)
          flag_mismatch($sformatf("coord_y %0d, want %0d", coord_y_o, $signed(want.y)));
        if (coord_z_o !== want.z)
          flag_mismatch($sformatf("coord_z %0d, want %0d", coord_z_o, $signed(want.z)));
        if (index_error_o !== want.err)
          flag_mismatch($sformatf("index_error %0b, want %0b", index_error_o, want.err));
      end
    end
  end

  initial begin
    // reset configuration: poles, ring corners, out-of-range and undefined func
    add_vertex(uvsg_pkg::FN_TOP, 8'd0, 8'd0, 0);
    add_vertex(uvsg_pkg::FN_TOP, 8'd255, 8'd255, 0);
    add_vertex(uvsg_pkg::FN_BOTTOM, 8'd0, 8'd0, 0);
    add_vertex(uvsg_pkg::FN_BOTTOM, 8'd255, 8'd255, 0);
    add_vertex(uvsg_pkg::FN_RING, 8'd0, 8'd0, 0);
    add_vertex(uvsg_pkg::FN_RING, 8'd0, 8'd4, 0);
    add_vertex(uvsg_pkg::FN_RING, 8'd3, 8'd0, 0);
    add_vertex(uvsg_pkg::FN_RING, 8'd3, 8'd12, 0);
    add_vertex(uvsg_pkg::FN_RING, 8'd7, 8'd8, 0);
    add_vertex(uvsg_pkg::FN_RING, 8'd7, 8'd15, 0);
    add_vertex(uvsg_pkg::FN_RING, 8'd8, 8'd0, 2);
    add_vertex(uvsg_pkg::FN_RING, 8'd0, 8'd16, 0);
    add_vertex(uvsg_pkg::FN_RING, 8'd255, 8'd0, 5);
    add_vertex(uvsg_pkg::FN_RING, 8'd0, 8'd255, 0);
    add_vertex(uvsg_pkg::FN_RING, 8'd255, 8'd255, 1);
    add_vertex(uvsg_pkg::FN_ERROR, 8'd0, 8'd0, 0);
    add_vertex(uvsg_pkg::FN_ERROR, 8'd3, 8'd5, 0);
    add_vertex(uvsg_pkg::FN_ERROR, 8'd255, 8'd255, 12);
    add_settle();
    add_random_phase(100, 1'b1);

    // largest sphere, back to back
    add_sphere(16'hFFFF, 16'd256, 16'd256);
    add_vertex(uvsg_pkg::FN_RING, 8'd255, 8'd255, 0);
    add_vertex(uvsg_pkg::FN_RING, 8'd0, 8'd0, 0);
    add_vertex(uvsg_pkg::FN_RING, 8'd127, 8'd64, 0);
    add_vertex(uvsg_pkg::FN_BOTTOM, 8'd0, 8'd0, 0);
    add_random_phase(100, 1'b0);

    // smallest counts
    add_sphere(16'd1, 16'd3, 16'd1);
    add_vertex(uvsg_pkg::FN_RING, 8'd0, 8'd0, 0);
    add_vertex(uvsg_pkg::FN_RING, 8'd0, 8'd1, 0);
    add_vertex(uvsg_pkg::FN_RING, 8'd0, 8'd2, 0);
    add_vertex(uvsg_pkg::FN_RING, 8'd0, 8'd3, 0);
    add_vertex(uvsg_pkg::FN_RING, 8'd1, 8'd0, 0);
    add_random_phase(80, 1'b1);

    // zero radius
    add_sphere(16'd0, 16'd16, 16'd8);
    add_random_phase(50, 1'b1);

    // zero sector count, then zero stack count
    add_sphere(CFG_DATA_W'($urandom_range(1, 65535)), 16'd0, 16'd5);
    add_random_phase(40, 1'b1);
    add_sphere(CFG_DATA_W'($urandom_range(1, 65535)), 16'd7, 16'd0);
    add_random_phase(40, 1'b1);

    // counts above the maximum, upper data bits ignored, spare index ignored
    add_sphere(CFG_DATA_W'($urandom_range(1, 65535)), 16'hFFFF, 16'd300);
    add_config(CFG_SPARE, CFG_DATA_W'($urandom));
    add_random_phase(80, 1'b1);

    repeat (3) begin
      add_sphere(CFG_DATA_W'($urandom_range(1, 65535)),
                 CFG_DATA_W'($urandom_range(3, 256)),
                 CFG_DATA_W'($urandom_range(1, 256)));
      add_random_phase(130, 1'b1);
    end

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (sphere_jobs.size() != 0 || start || cfg_valid_i || vertex_due.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("PASS uv_sphere_vertex_generator_top");
    end else begin
      $display("FAIL uv_sphere_vertex_generator_top");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("FAIL uv_sphere_vertex_generator_top");
    $finish;
  end

endmodule
